FILE: hw/rtl/pmu_pkg.sv
// ----------------------------------------------------------------------------
// pmu_pkg
// Shared types, constants and entry helpers of the progress measure unit.
// ----------------------------------------------------------------------------
package pmu_pkg;

    // Measure layout: one counter per odd priority, packed from bit zero
    localparam int ODD_ENTRIES = 4;
    localparam int ENTRY_BITS  = 16;
    localparam int VEC_BITS    = 64;
    localparam int PCNT_BITS   = 4;
    localparam int BND_BITS    = 3;
    localparam int MODE_BITS   = 2;

    // Operation codes
    localparam logic [MODE_BITS-1:0] MODE_SUCC   = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_COPY   = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_GREATER = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_LESS   = 2'd3;

    // Configuration register indexes
    localparam logic CFG_PRIORITY_COUNT = 1'b0;
    localparam logic CFG_MAX_VECTOR     = 1'b1;

    typedef logic [ENTRY_BITS-1:0] t_entry;
    typedef t_entry [ODD_ENTRIES-1:0] t_entries;

    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        logic [BND_BITS-1:0]  boundary;
        logic [VEC_BITS-1:0]  operand_a;
        logic [VEC_BITS-1:0]  operand_b;
    } t_req;

    typedef struct packed {
        logic [VEC_BITS-1:0] result_vector;
        logic                flag;
        logic                result_is_top;
        logic                range_error;
    } t_rsp;

    // Split a packed measure into entries; bits past the vector read as zero
    function automatic t_entries unpack_vec(input logic [VEC_BITS-1:0] v);
        t_entries e;
        int       pos;
        e = '0;
        for (int k = 0; k < ODD_ENTRIES; k++) begin
            for (int i = 0; i < ENTRY_BITS; i++) begin
                pos = k * ENTRY_BITS + i;
                if (pos < VEC_BITS) begin
                    e[k][i] = v[pos[5:0]];
                end
            end
        end
        return e;
    endfunction

    // Pack entries into a measure; bits past the vector are dropped
    function automatic logic [VEC_BITS-1:0] pack_vec(input t_entries e);
        logic [VEC_BITS-1:0] v;
        int                  pos;
        v = '0;
        for (int k = 0; k < ODD_ENTRIES; k++) begin
            for (int i = 0; i < ENTRY_BITS; i++) begin
                pos = k * ENTRY_BITS + i;
                if (pos < VEC_BITS) begin
                    v[pos[5:0]] = e[k][i];
                end
            end
        end
        return v;
    endfunction

endpackage

FILE: hw/rtl/progress_measure_unit_top.sv
// ----------------------------------------------------------------------------
// progress_measure_unit_top
// Progress measure unit for parity-game lifting: one measure op per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_valid/o_ready with an i_req payload (mode, boundary,
//   operand_a, operand_b); responses leave on o_valid/i_ready with o_rsp.
//   The configuration port (i_cfg_we, i_cfg_index, i_cfg_data) writes the
//   priority count and the maximum vector; the user must do so only with
//   the unit idle, which the unit itself does not enforce.
//   The input register feeds one pass through the operation logic into the
//   response register. The unit takes one request per cycle while the
//   receiver keeps i_ready high; the operation logic between the two
//   registers is a single pass.
//   Reset clears both stage valid bits and loads priority count 8 and an
//   all-ones maximum vector.
//   When the receiver stalls, the response register holds and the input
//   register still takes one more request; o_ready drops only when both
//   stages are full and i_ready is low.
// ----------------------------------------------------------------------------
module progress_measure_unit_top
    import pmu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_req                 i_req,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_rsp                 o_rsp,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [VEC_BITS-1:0]  i_cfg_data
);

    logic [PCNT_BITS-1:0] r_priority_count;
    logic [VEC_BITS-1:0]  r_max_vector;
    logic                 r_in_valid;
    t_req                 r_req;
    logic                 r_out_valid;
    t_rsp                 r_rsp;
    t_rsp                 n_rsp;
    logic                 out_free;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_priority_count <= PCNT_BITS'(8);
            r_max_vector     <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PRIORITY_COUNT: r_priority_count <= i_cfg_data[PCNT_BITS-1:0];
                CFG_MAX_VECTOR:     r_max_vector     <= i_cfg_data;
                default:            r_max_vector     <= r_max_vector;
            endcase
        end
    end

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = !r_in_valid || out_free;

    // Input stage: take a request whenever the stage is empty or moving on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
    end

    pmu_core u_core (
        .i_req            (r_req),
        .i_priority_count (r_priority_count),
        .i_max_vector     (r_max_vector),
        .o_rsp            (n_rsp)
    );

    // Response stage: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_in_valid) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

`ifndef SYNTHESIS
    a_err_clears_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_rsp.range_error |->
            (r_rsp.result_vector == '0) && !r_rsp.flag && !r_rsp.result_is_top)
        else $error("range error response carries nonzero fields");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_valid && !r_out_valid)
        else $error("pipeline not empty after reset");

    a_stalled_req_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !out_free |=> r_in_valid)
        else $error("request dropped from input stage during stall");

    a_full_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_ready |-> !o_ready)
        else $error("ready high with both stages full and stalled");
`endif

endmodule

FILE: hw/rtl/pmu_core.sv
// ----------------------------------------------------------------------------
// pmu_core
// Single-pass measure operation: successor, prefix copy and the two compares.
// ----------------------------------------------------------------------------
module pmu_core
    import pmu_pkg::*;
(
    input  t_req                  i_req,
    input  logic [PCNT_BITS-1:0]  i_priority_count,
    input  logic [VEC_BITS-1:0]   i_max_vector,
    output t_rsp                  o_rsp
);

    t_entries                a_e;
    t_entries                b_e;
    t_entries                m_e;
    t_entries                succ_e;
    t_entries                copy_e;
    logic [ODD_ENTRIES-1:0]  prefix;
    logic [ODD_ENTRIES-1:0]  below;
    logic [ODD_ENTRIES-1:0]  later_below;
    logic [BND_BITS-1:0]     last_idx;
    logic                    b_top;
    logic                    any_below;
    logic                    gt_flag;
    logic                    lt_flag;
    logic                    err;
    logic [VEC_BITS-1:0]     max_canon;
    logic [VEC_BITS-1:0]     res;

    assign a_e       = unpack_vec(i_req.operand_a);
    assign b_e       = unpack_vec(i_req.operand_b);
    assign m_e       = unpack_vec(i_max_vector);
    assign max_canon = pack_vec(m_e);
    assign last_idx  = i_req.boundary >> 1;
    assign err       = (i_req.mode != MODE_LESS) &&
                       ({1'b0, i_req.boundary} >= i_priority_count);

    // Mark prefix entries and those still below their maximum
    always_comb begin
        b_top = 1'b1;
        for (int k = 0; k < ODD_ENTRIES; k++) begin
            prefix[k] = (BND_BITS'(k) <= last_idx) || (k == ODD_ENTRIES - 1 &&
                        int'(last_idx) >= ODD_ENTRIES - 1);
            below[k]  = prefix[k] && (b_e[k] < m_e[k]);
            if (b_e[k] != m_e[k]) begin
                b_top = 1'b0;
            end
        end
    end

    // Increment the last entry below maximum, keep earlier, clear later
    always_comb begin
        later_below = '0;
        for (int k = ODD_ENTRIES - 2; k >= 0; k--) begin
            later_below[k] = later_below[k+1] | below[k+1];
        end
        any_below = |below;
        for (int j = 0; j < ODD_ENTRIES; j++) begin
            if (later_below[j]) begin
                succ_e[j] = b_e[j];
            end else if (below[j]) begin
                succ_e[j] = b_e[j] + t_entry'(1);
            end else begin
                succ_e[j] = '0;
            end
            copy_e[j] = prefix[j] ? b_e[j] : '0;
        end
    end

    // Compare from the high entry down so the lowest differing entry decides
    always_comb begin
        gt_flag = 1'b0;
        lt_flag = 1'b0;
        for (int k = ODD_ENTRIES - 1; k >= 0; k--) begin
            if (prefix[k] && (a_e[k] != b_e[k])) begin
                gt_flag = (a_e[k] > b_e[k]);
            end
            if (a_e[k] != b_e[k]) begin
                lt_flag = (a_e[k] < b_e[k]);
            end
        end
    end

    // Select the result by mode
    always_comb begin
        o_rsp = '0;
        res   = '0;
        if (err) begin
            o_rsp.range_error = 1'b1;
        end else begin
            unique case (i_req.mode)
                MODE_SUCC: begin
                    if (b_top || !any_below) begin
                        res = max_canon;
                    end else begin
                        res        = pack_vec(succ_e);
                        o_rsp.flag = 1'b1;
                    end
                    o_rsp.result_vector = res;
                    o_rsp.result_is_top = (res == max_canon);
                end
                MODE_COPY: begin
                    res                 = b_top ? max_canon : pack_vec(copy_e);
                    o_rsp.result_vector = res;
                    o_rsp.result_is_top = (res == max_canon);
                end
                MODE_GREATER: begin
                    o_rsp.flag = gt_flag;
                end
                MODE_LESS: begin
                    o_rsp.flag = lt_flag;
                end
                default: begin
                    o_rsp = '0;
                end
            endcase
        end
    end

endmodule

FILE: bench/progress_measure_unit_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// progress_measure_unit_top_tb
// Self-checking bench for the progress measure unit.
// ----------------------------------------------------------------------------
// Requests go in through a valid/ready sender task and are predicted at the
// accepting edge by a local model of successor, prefix copy and the two
// compares. A response monitor checks each response field by field against
// the oldest prediction. Directed corners come first, then random streams
// under several idle and stall mixes, a long receiver hold-off and a sender
// pause. Configuration is written only with the unit drained.
// ----------------------------------------------------------------------------
module progress_measure_unit_top_tb
    import pmu_pkg::*;
;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 3;
    localparam int LONG_HOLD      = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 150;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    t_req                i_req;
    logic                o_valid;
    logic                i_ready;
    t_rsp                o_rsp;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [VEC_BITS-1:0] i_cfg_data;

    // Local copy of the configuration registers
    logic [PCNT_BITS-1:0] model_pcnt;
    logic [VEC_BITS-1:0]  model_max;

    t_rsp pending_measures[$];
    int   errors         = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   hold_requests  = 0;
    int   quiet_cycles   = 0;

    progress_measure_unit_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Compute the response of one request from the current configuration
    function automatic t_rsp measure_op(input t_req r, input logic [PCNT_BITS-1:0] pcnt,
                                        input logic [VEC_BITS-1:0] maxv);
        t_entry a_e [ODD_ENTRIES];
        t_entry b_e [ODD_ENTRIES];
        t_entry m_e [ODD_ENTRIES];
        t_entry r_e [ODD_ENTRIES];
        t_rsp   rsp;
        int     last;
        int     sel;
        bit     b_top;
        bit     r_top;
        rsp = '0;
        for (int k = 0; k < ODD_ENTRIES; k++) begin
            a_e[k] = r.operand_a[k*ENTRY_BITS +: ENTRY_BITS];
            b_e[k] = r.operand_b[k*ENTRY_BITS +: ENTRY_BITS];
            m_e[k] = maxv[k*ENTRY_BITS +: ENTRY_BITS];
            r_e[k] = '0;
        end
        last = int'(r.boundary) / 2;
        if (last > ODD_ENTRIES - 1) begin
            last = ODD_ENTRIES - 1;
        end
        b_top = 1'b1;
        for (int k = 0; k < ODD_ENTRIES; k++) begin
            if (b_e[k] != m_e[k]) begin
                b_top = 1'b0;
            end
        end
        // The lexicographic compare ignores the boundary entirely
        if (r.mode != MODE_LESS && {1'b0, r.boundary} >= pcnt) begin
            rsp.range_error = 1'b1;
        end else begin
            case (r.mode)
                MODE_SUCC, MODE_COPY: begin
                    if (b_top) begin
                        r_e = m_e;
                    end else if (r.mode == MODE_SUCC) begin
                        // Bump the last prefix entry still below its maximum
                        sel = -1;
                        for (int k = last; k >= 0; k--) begin
                            if (sel < 0 && b_e[k] < m_e[k]) begin
                                sel = k;
                            end
                        end
                        if (sel < 0) begin
                            r_e = m_e;
                        end else begin
                            for (int k = 0; k < sel; k++) begin
                                r_e[k] = b_e[k];
                            end
                            r_e[sel] = b_e[sel] + 1'b1;
                            rsp.flag = 1'b1;
                        end
                    end else begin
                        for (int k = 0; k <= last; k++) begin
                            r_e[k] = b_e[k];
                        end
                    end
                    r_top = 1'b1;
                    for (int k = 0; k < ODD_ENTRIES; k++) begin
                        if (r_e[k] != m_e[k]) begin
                            r_top = 1'b0;
                        end
                        rsp.result_vector[k*ENTRY_BITS +: ENTRY_BITS] = r_e[k];
                    end
                    rsp.result_is_top = r_top;
                end
                MODE_GREATER: begin
                    sel = -1;
                    for (int k = 0; k <= last; k++) begin
                        if (sel < 0 && a_e[k] != b_e[k]) begin
                            sel = k;
                            rsp.flag = (a_e[k] > b_e[k]);
                        end
                    end
                end
                default: begin
                    sel = -1;
                    for (int k = 0; k < ODD_ENTRIES; k++) begin
                        if (sel < 0 && a_e[k] != b_e[k]) begin
                            sel = k;
                            rsp.flag = (a_e[k] < b_e[k]);
                        end
                    end
                end
            endcase
        end
        return rsp;
    endfunction

    // Pick an entry near the interesting points of its maximum
    function automatic t_entry pick_entry(input t_entry lim);
        t_entry e;
        case ($urandom_range(0, 5))
            0: e = '0;
            1: e = lim;
            2: e = lim - 1'b1;
            3: e = lim + 1'b1;
            4: e = t_entry'($urandom_range(0, 3));
            default: e = t_entry'($urandom);
        endcase
        return e;
    endfunction

    function automatic logic [VEC_BITS-1:0] random_max();
        logic [VEC_BITS-1:0] v;
        for (int k = 0; k < ODD_ENTRIES; k++) begin
            case ($urandom_range(0, 3))
                0: v[k*ENTRY_BITS +: ENTRY_BITS] = t_entry'($urandom_range(0, 3));
                1: v[k*ENTRY_BITS +: ENTRY_BITS] = '1;
                2: v[k*ENTRY_BITS +: ENTRY_BITS] = t_entry'($urandom_range(0, 15));
                default: v[k*ENTRY_BITS +: ENTRY_BITS] = t_entry'($urandom);
            endcase
        end
        return v;
    endfunction

    // Build a request whose operands sit mostly on the edges of the maximum
    function automatic t_req random_req();
        t_req r;
        int   k;
        r.mode     = MODE_BITS'($urandom_range(0, 3));
        r.boundary = BND_BITS'($urandom_range(0, 7));
        for (int j = 0; j < ODD_ENTRIES; j++) begin
            r.operand_b[j*ENTRY_BITS +: ENTRY_BITS] =
                pick_entry(model_max[j*ENTRY_BITS +: ENTRY_BITS]);
        end
        if ($urandom_range(0, 7) == 0) begin
            r.operand_b = {$urandom, $urandom};
        end
        case ($urandom_range(0, 3))
            0: begin
                r.operand_a = r.operand_b;
            end
            1: begin
                // Differ from b in one entry by one step
                r.operand_a = r.operand_b;
                k = $urandom_range(0, ODD_ENTRIES - 1);
                if ($urandom_range(0, 1)) begin
                    r.operand_a[k*ENTRY_BITS +: ENTRY_BITS] =
                        r.operand_b[k*ENTRY_BITS +: ENTRY_BITS] + 1'b1;
                end else begin
                    r.operand_a[k*ENTRY_BITS +: ENTRY_BITS] =
                        r.operand_b[k*ENTRY_BITS +: ENTRY_BITS] - 1'b1;
                end
            end
            2: begin
                r.operand_a = {$urandom, $urandom};
            end
            default: begin
                for (int j = 0; j < ODD_ENTRIES; j++) begin
                    r.operand_a[j*ENTRY_BITS +: ENTRY_BITS] =
                        pick_entry(model_max[j*ENTRY_BITS +: ENTRY_BITS]);
                end
            end
        endcase
        return r;
    endfunction

    // Offer one request, idling first at random, and predict it on accept
    task automatic send_req(input t_req r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        pending_measures.push_back(measure_op(r, model_pcnt, model_max));
    endtask

    task automatic send_op(input logic [MODE_BITS-1:0] mode, input logic [BND_BITS-1:0] bnd,
                           input logic [VEC_BITS-1:0] a, input logic [VEC_BITS-1:0] b);
        t_req r;
        r.mode      = mode;
        r.boundary  = bnd;
        r.operand_a = a;
        r.operand_b = b;
        send_req(r);
    endtask

    // Drop valid and wait for every outstanding response
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_measures.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [VEC_BITS-1:0] data);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (idx == CFG_PRIORITY_COUNT) begin
            model_pcnt = data[PCNT_BITS-1:0];
        end else begin
            model_max = data;
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++) begin
            send_req(random_req());
        end
    endtask

    task automatic test_successor_corners();
        send_op(MODE_SUCC, 3'd0, '0, '0);
        send_op(MODE_SUCC, 3'd7, '1, '0);
        send_op(MODE_SUCC, 3'd7, '0, '1);
        send_op(MODE_SUCC, 3'd7, '0, 64'hFFFF_1234_1234_1234);
        send_op(MODE_SUCC, 3'd3, '0, 64'h5A5A_A5A5_FFFF_FFFF);
        send_op(MODE_SUCC, 3'd2, '0, 64'h0005_0004_0003_0002);
    endtask

    task automatic test_copy_and_compare();
        send_op(MODE_COPY, 3'd0, '1, 64'h8001_7FFE_C3C3_3C3C);
        send_op(MODE_COPY, 3'd7, '0, '1);
        send_op(MODE_COPY, 3'd5, '0, 64'h0123_4567_89AB_CDEF);
        send_op(MODE_GREATER, 3'd7, 64'h1111_2222_3333_4444, 64'h1111_2222_3333_4444);
        send_op(MODE_GREATER, 3'd7, 64'h0002_0000_0000_0000, 64'h0001_0000_0000_0000);
        send_op(MODE_GREATER, 3'd1, 64'h0002_0000_0000_0000, 64'h0001_0000_0000_0000);
        send_op(MODE_GREATER, 3'd7, 64'h0000_0000_0000_0001, 64'h0000_0000_0000_0002);
        send_op(MODE_LESS, 3'd7, 64'hABCD_0000_0000_0000, 64'hABCD_0000_0000_0000);
        send_op(MODE_LESS, 3'd0, 64'h0001_0000_0000_0000, 64'h0002_0000_0000_0000);
        send_op(MODE_LESS, 3'd7, 64'h0000_0000_0000_0002, 64'hFFFF_FFFF_FFFF_0001);
        send_op(MODE_LESS, 3'd7, '0, '1);
    endtask

    // Hit the boundary check at the smallest and widest priority counts
    task automatic test_boundary_limits();
        write_reg(CFG_PRIORITY_COUNT, 64'd1);
        send_op(MODE_SUCC, 3'd1, '0, '0);
        send_op(MODE_COPY, 3'd0, '0, 64'h0000_0000_0000_BEEF);
        send_op(MODE_GREATER, 3'd7, '1, '0);
        send_op(MODE_LESS, 3'd7, '0, '1);
        write_reg(CFG_PRIORITY_COUNT, 64'd0);
        send_op(MODE_SUCC, 3'd0, '0, '0);
        send_op(MODE_LESS, 3'd0, '1, '0);
        // Upper data bits carry junk that the register must ignore
        write_reg(CFG_PRIORITY_COUNT, 64'hDEAD_BEEF_0000_000F);
        send_op(MODE_COPY, 3'd7, '0, 64'h0042_0041_0040_003F);
    endtask

    task automatic test_tight_maximum();
        write_reg(CFG_PRIORITY_COUNT, 64'd8);
        write_reg(CFG_MAX_VECTOR, 64'h0003_0002_0001_0000);
        send_op(MODE_SUCC, 3'd7, '0, 64'h0003_0002_0001_0000);
        send_op(MODE_SUCC, 3'd7, '0, 64'h0000_FFFF_FFFF_FFFF);
        send_op(MODE_SUCC, 3'd7, '0, '0);
        send_op(MODE_COPY, 3'd2, '0, 64'h0003_0002_0001_0000);
        write_reg(CFG_MAX_VECTOR, '0);
        send_op(MODE_SUCC, 3'd7, '0, '0);
        send_op(MODE_SUCC, 3'd4, '0, 64'h0001_0000_0000_0000);
    endtask

    task automatic test_random_streams();
        // No idling on either side
        write_reg(CFG_PRIORITY_COUNT, 64'd8);
        write_reg(CFG_MAX_VECTOR, random_max());
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random(PHASE_ITEMS);
        // Sender mostly idle
        write_reg(CFG_PRIORITY_COUNT, {$urandom, $urandom_range(1, 8)});
        write_reg(CFG_MAX_VECTOR, '1);
        send_idle_pct  = 83;
        recv_stall_pct = 0;
        send_random(PHASE_ITEMS);
        // Receiver mostly stalled
        write_reg(CFG_PRIORITY_COUNT, 64'd4);
        write_reg(CFG_MAX_VECTOR, {$urandom, $urandom});
        send_idle_pct  = 0;
        recv_stall_pct = 83;
        send_random(PHASE_ITEMS);
        // Both sides idle part of the time
        write_reg(CFG_PRIORITY_COUNT,
                  64'({$urandom_range(0, 15), 4'd0} | $urandom_range(1, 8)));
        write_reg(CFG_MAX_VECTOR, random_max());
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        send_random(PHASE_ITEMS);
    endtask

    // Hold the receiver off while requests keep coming until input stalls
    task automatic test_output_backpressure();
        write_reg(CFG_PRIORITY_COUNT, 64'd8);
        write_reg(CFG_MAX_VECTOR, random_max());
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests++;
        send_random(24);
    endtask

    task automatic test_sender_pause();
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        send_random(12);
        drain();
        send_random(12);
    endtask

    // Drive the receiver ready, with a long hold-off on request
    initial begin : receiver
        int hold_served;
        int hold_cnt;
        hold_served = 0;
        i_ready     = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                for (hold_cnt = 0; hold_cnt < LONG_HOLD; hold_cnt++) begin
                    i_ready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Check each response against the oldest prediction
    always @(posedge i_clk) begin : response_check
        t_rsp want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_measures.size() == 0) begin
                $error("unexpected response %h", o_rsp);
                errors++;
            end else begin
                want = pending_measures.pop_front();
                if (o_rsp.result_vector !== want.result_vector) begin
                    $error("result_vector: expected %h, got %h",
                           want.result_vector, o_rsp.result_vector);
                    errors++;
                end
                if (o_rsp.flag !== want.flag) begin
                    $error("flag: expected %b, got %b", want.flag, o_rsp.flag);
                    errors++;
                end
                if (o_rsp.result_is_top !== want.result_is_top) begin
                    $error("result_is_top: expected %b, got %b",
                           want.result_is_top, o_rsp.result_is_top);
                    errors++;
                end
                if (o_rsp.range_error !== want.range_error) begin
                    $error("range_error: expected %b, got %b",
                           want.range_error, o_rsp.range_error);
                    errors++;
                end
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_req       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_PRIORITY_COUNT;
        i_cfg_data  = '0;
        model_pcnt  = 4'd8;
        model_max   = '1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_successor_corners();
        test_copy_and_compare();
        test_boundary_limits();
        test_tight_maximum();
        test_random_streams();
        test_output_backpressure();
        test_sender_pause();

        drain();
        repeat (8) @(posedge i_clk);
        if (errors == 0 && pending_measures.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
